// ----- hdl/bbs_pkg.sv -----
`default_nettype none

package bbs_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_LOAD,
        ST_STEP,
        ST_FLUSH,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/bbs_cswap.sv -----
`default_nettype none

module bbs_cswap #(
    parameter int KEY_W      = 32,
    parameter bit KEY_SIGNED = 1'b1
) (
    input  wire logic                       i_fwd,
    input  wire logic [KEY_W-1:0]           i_carry_key,
    input  wire logic [bbs_pkg::DATA_W-1:0] i_carry_pay,
    input  wire logic [KEY_W-1:0]           i_rd_key,
    input  wire logic [bbs_pkg::DATA_W-1:0] i_rd_pay,
    output logic                            o_swap,
    output logic [KEY_W-1:0]                o_wr_key,
    output logic [bbs_pkg::DATA_W-1:0]      o_wr_pay,
    output logic [KEY_W-1:0]                o_carry_key,
    output logic [bbs_pkg::DATA_W-1:0]      o_carry_pay
);
    import bbs_pkg::*;

    localparam logic [KEY_W-1:0] BIAS = KEY_SIGNED ? {1'b1, {(KEY_W-1){1'b0}}} : '0;

    logic [KEY_W-1:0] carry_b;
    logic [KEY_W-1:0] rd_b;

    // offset binary so one unsigned compare serves signed keys too
    assign carry_b = i_carry_key ^ BIAS;
    assign rd_b    = i_rd_key ^ BIAS;

    // forward: carry sits below the read entry, backward: above it
    assign o_swap = i_fwd ? (carry_b > rd_b) : (rd_b > carry_b);

    always_comb begin
        if (o_swap) begin
            o_wr_key    = i_rd_key;
            o_wr_pay    = i_rd_pay;
            o_carry_key = i_carry_key;
            o_carry_pay = i_carry_pay;
        end else begin
            o_wr_key    = i_carry_key;
            o_wr_pay    = i_carry_pay;
            o_carry_key = i_rd_key;
            o_carry_pay = i_rd_pay;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bidirectional_bubble_sort.sv -----
`default_nettype none

// Cocktail shaker sort of up to MAX_ITEMS keyed records. Records are loaded one
// per cycle while busy is low; the request flagged final starts the sort. The
// sort keeps one record in a carry register and walks a record memory with one
// read and one write port, one compare per cycle through one shared
// compare-and-select unit, plus setup (ST_PRIME, ST_LOAD) and write-back
// (ST_FLUSH) states per pass. After that the sorted records come out one per
// cycle on o_strobe. Results cannot be held off: each one is on the ports for
// exactly one cycle, and the next request may be given in the cycle of the
// last one. An empty-set request gives one result, in the next cycle.
module bidirectional_bubble_sort #(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_BITS  = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    input  wire logic signed [bbs_pkg::DATA_W-1:0] i_key,
    input  wire logic        [bbs_pkg::DATA_W-1:0] i_payload,
    input  wire logic                              i_final_item,
    input  wire logic                              i_empty_set,
    output logic                                   busy,
    output logic                                   o_strobe,
    output logic signed [bbs_pkg::DATA_W-1:0]      o_sorted_key,
    output logic        [bbs_pkg::DATA_W-1:0]      o_sorted_payload,
    output logic        [bbs_pkg::CNT_W-1:0]       o_compare_total,
    output logic        [bbs_pkg::CNT_W-1:0]       o_swap_total,
    output logic                                   o_run_end,
    output logic                                   o_no_records
);
    import bbs_pkg::*;

    localparam int  AW         = $clog2(MAX_ITEMS);
    localparam int  CW         = $clog2(MAX_ITEMS + 1);
    localparam int  SW         = (KEY_BITS < DATA_W) ? KEY_BITS : DATA_W;
    localparam bit  KEY_SIGNED = (KEY_BITS <= DATA_W);

    logic [SW-1:0]     mem_key [MAX_ITEMS];
    logic [DATA_W-1:0] mem_pay [MAX_ITEMS];

    t_state r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_n, n_n;
    logic [AW-1:0]     r_lo, n_lo;
    logic [AW-1:0]     r_hi, n_hi;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic              r_fwd, n_fwd;
    logic              r_swapped, n_swapped;
    logic [CNT_W-1:0]  r_cmp, n_cmp;
    logic [CNT_W-1:0]  r_swp, n_swp;
    logic [SW-1:0]     r_carry_key, n_carry_key;
    logic [DATA_W-1:0] r_carry_pay, n_carry_pay;
    logic [SW-1:0]     r_rd_key;
    logic [DATA_W-1:0] r_rd_pay;
    logic              r_ovalid, n_ovalid;
    logic              r_olast, n_olast;
    logic              r_onorec, n_onorec;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [SW-1:0]     wr_key;
    logic [DATA_W-1:0] wr_pay;
    logic [CW-1:0]     total;

    logic              cs_swap;
    logic [SW-1:0]     cs_wr_key;
    logic [DATA_W-1:0] cs_wr_pay;
    logic [SW-1:0]     cs_carry_key;
    logic [DATA_W-1:0] cs_carry_pay;

    bbs_cswap #(
        .KEY_W      (SW),
        .KEY_SIGNED (KEY_SIGNED)
    ) u_cswap (
        .i_fwd       (r_fwd),
        .i_carry_key (r_carry_key),
        .i_carry_pay (r_carry_pay),
        .i_rd_key    (r_rd_key),
        .i_rd_pay    (r_rd_pay),
        .o_swap      (cs_swap),
        .o_wr_key    (cs_wr_key),
        .o_wr_pay    (cs_wr_pay),
        .o_carry_key (cs_carry_key),
        .o_carry_pay (cs_carry_pay)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_key[wr_addr] <= wr_key;
            mem_pay[wr_addr] <= wr_pay;
        end
        if (rd_en) begin
            r_rd_key <= mem_key[rd_addr];
            r_rd_pay <= mem_pay[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_n       <= '0;
            r_lo      <= '0;
            r_hi      <= '0;
            r_ptr     <= '0;
            r_fwd     <= 1'b1;
            r_swapped <= 1'b0;
            r_cmp     <= '0;
            r_swp     <= '0;
            r_ovalid  <= 1'b0;
            r_olast   <= 1'b0;
            r_onorec  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_n       <= n_n;
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            r_ptr     <= n_ptr;
            r_fwd     <= n_fwd;
            r_swapped <= n_swapped;
            r_cmp     <= n_cmp;
            r_swp     <= n_swp;
            r_ovalid  <= n_ovalid;
            r_olast   <= n_olast;
            r_onorec  <= n_onorec;
        end
        r_carry_key <= n_carry_key;
        r_carry_pay <= n_carry_pay;
    end

    assign total = (r_cnt < CW'(MAX_ITEMS)) ? CW'(r_cnt + 1'b1) : r_cnt;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_ptr       = r_ptr;
        n_fwd       = r_fwd;
        n_swapped   = r_swapped;
        n_cmp       = r_cmp;
        n_swp       = r_swp;
        n_carry_key = r_carry_key;
        n_carry_pay = r_carry_pay;
        n_ovalid    = 1'b0;
        n_olast     = 1'b0;
        n_onorec    = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_ptr;
        wr_en       = 1'b0;
        wr_addr     = r_ptr;
        wr_key      = cs_wr_key;
        wr_pay      = cs_wr_pay;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_empty_set) begin
                        n_cnt    = '0;
                        n_cmp    = '0;
                        n_swp    = '0;
                        n_ovalid = 1'b1;
                        n_olast  = 1'b1;
                        n_onorec = 1'b1;
                    end else begin
                        // records past the capacity are dropped
                        if (r_cnt < CW'(MAX_ITEMS)) begin
                            wr_en   = 1'b1;
                            wr_addr = r_cnt[AW-1:0];
                            wr_key  = i_key[SW-1:0];
                            wr_pay  = i_payload;
                            n_cnt   = CW'(r_cnt + 1'b1);
                        end
                        if (i_final_item) begin
                            n_cnt     = '0;
                            n_n       = total;
                            n_lo      = '0;
                            n_hi      = AW'(total - 1'b1);
                            n_fwd     = 1'b1;
                            n_swapped = 1'b0;
                            n_cmp     = '0;
                            n_swp     = '0;
                            n_state   = ST_PRIME;
                        end
                    end
                end
            end

            ST_PRIME: begin
                if (r_lo >= r_hi) begin
                    n_ptr   = '0;
                    n_state = ST_OUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_fwd ? r_lo : r_hi;
                    n_state = ST_LOAD;
                end
            end

            ST_LOAD: begin
                n_carry_key = r_rd_key;
                n_carry_pay = r_rd_pay;
                rd_en       = 1'b1;
                rd_addr     = r_fwd ? AW'(r_lo + 1'b1) : AW'(r_hi - 1'b1);
                n_ptr       = rd_addr;
                n_state     = ST_STEP;
            end

            ST_STEP: begin
                // read data holds the entry at r_ptr, carry its neighbor
                n_carry_key = cs_carry_key;
                n_carry_pay = cs_carry_pay;
                wr_en       = 1'b1;
                wr_addr     = r_fwd ? AW'(r_ptr - 1'b1) : AW'(r_ptr + 1'b1);
                n_cmp       = CNT_W'(r_cmp + 1'b1);
                if (cs_swap) begin
                    n_swp     = CNT_W'(r_swp + 1'b1);
                    n_swapped = 1'b1;
                end
                if (r_fwd ? (r_ptr == r_hi) : (r_ptr == r_lo)) begin
                    n_state = ST_FLUSH;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_fwd ? AW'(r_ptr + 1'b1) : AW'(r_ptr - 1'b1);
                    n_ptr   = rd_addr;
                end
            end

            ST_FLUSH: begin
                wr_en     = 1'b1;
                wr_addr   = r_fwd ? r_hi : r_lo;
                wr_key    = r_carry_key;
                wr_pay    = r_carry_pay;
                n_swapped = 1'b0;
                n_fwd     = !r_fwd;
                if (r_fwd) begin
                    n_hi = AW'(r_hi - 1'b1);
                end else begin
                    n_lo = AW'(r_lo + 1'b1);
                end
                if (r_swapped) begin
                    n_state = ST_PRIME;
                end else begin
                    n_ptr   = '0;
                    n_state = ST_OUT;
                end
            end

            ST_OUT: begin
                rd_en    = 1'b1;
                rd_addr  = r_ptr;
                n_ovalid = 1'b1;
                n_ptr    = AW'(r_ptr + 1'b1);
                if (CW'(r_ptr) + 1'b1 == r_n) begin
                    n_olast = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy             = (r_state != ST_IDLE);
    assign o_strobe         = r_ovalid;
    assign o_sorted_key     = r_onorec ? '0 : DATA_W'($signed(r_rd_key));
    assign o_sorted_payload = r_onorec ? '0 : r_rd_pay;
    assign o_compare_total  = r_cmp;
    assign o_swap_total     = r_swp;
    assign o_run_end        = r_olast;
    assign o_no_records     = r_onorec;

endmodule

`default_nettype wire
